### src/csvs_pkg.sv
`timescale 1ns / 1ps

package csvs_pkg;

  localparam int unsigned SlotCount = 16;
  localparam int unsigned IdxW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned HitsW     = 8;
  localparam int unsigned MinW      = HitsW + 1;
  localparam int unsigned VictimW   = 4;
  localparam int unsigned KindW     = 2;

  // Above every 8-bit hit count: marks a minimum that never got a slot.
  localparam logic [MinW-1:0] HitsCeiling = MinW'(9'h100);

  typedef logic [IdxW-1:0] slot_idx_t;
  typedef logic [MinW-1:0] min_hits_t;

  typedef enum logic [KindW-1:0] {
    KindEmpty      = 2'd0,
    KindCleanFit   = 2'd1,
    KindCleanSmall = 2'd2,
    KindAny        = 2'd3
  } choice_kind_e;

endpackage

### src/csvs_slot_if.sv
`timescale 1ns / 1ps

interface csvs_slot_if
  import csvs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             slot_occupied;
  logic             slot_dirty;
  logic [SizeW-1:0] slot_buffer_size;
  logic [HitsW-1:0] slot_hits;
  logic [SizeW-1:0] wanted_size;
  logic             last_slot;

  modport source (
    output valid, slot_occupied, slot_dirty, slot_buffer_size, slot_hits,
           wanted_size, last_slot,
    input  ready
  );

  modport sink (
    input  valid, slot_occupied, slot_dirty, slot_buffer_size, slot_hits,
           wanted_size, last_slot,
    output ready
  );
endinterface

### src/csvs_victim_if.sv
`timescale 1ns / 1ps

interface csvs_victim_if
  import csvs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VictimW-1:0] victim_slot;
  logic [KindW-1:0]   choice_kind;

  modport source (
    output valid, victim_slot, choice_kind,
    input  ready
  );

  modport sink (
    input  valid, victim_slot, choice_kind,
    output ready
  );
endinterface

### src/cache_slot_victim_select_core.sv
`timescale 1ns / 1ps

// Cache slot victim selection, least-hit replacement with empty slots first, then clean ones.
// slot_i: one beat per cache slot, slot 0 first; last_slot closes a request.
// victim_o: one beat per request, carrying the chosen slot and the kind of
//   choice (empty, clean fitting, clean small, least-hit any).
// Result path: the last slot beat lands in the input register, and the result
//   register loads from it once no earlier result is still waiting there.
// Throughput: one slot beat per cycle, sustained, including back-to-back
//   requests, while no last beat is stalled (see Stall). The running minima
//   are updated combinationally from the input register and registered, so
//   every slot sees the state left by the previous one.
// Stall: while a result waits in the output register, slot beats of the next
//   request keep flowing; only a following last beat waits in the input
//   register until the pending result is taken, and then slot_i deasserts
//   ready until that stage drains.
// Reset: asynchronous, active low; clears the input and result valids and
//   returns the slot position and all running minima to their idle values.
module cache_slot_victim_select_core
  import csvs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  csvs_slot_if.sink     slot_i,
  csvs_victim_if.source victim_o
);

  // Input register
  logic             in_valid_q;
  logic             in_occupied_q;
  logic             in_dirty_q;
  logic [SizeW-1:0] in_bsize_q;
  logic [HitsW-1:0] in_hits_q;
  logic [SizeW-1:0] in_wanted_q;
  logic             in_last_q;

  // Request state
  slot_idx_t pos_q,         pos_d;
  logic      empty_seen_q,  empty_seen_d;
  slot_idx_t empty_idx_q,   empty_idx_d;
  min_hits_t fit_min_q,     fit_min_d;
  slot_idx_t fit_idx_q,     fit_idx_d;
  min_hits_t clean_min_q,   clean_min_d;
  slot_idx_t clean_idx_q,   clean_idx_d;
  min_hits_t any_min_q,     any_min_d;
  slot_idx_t any_idx_q,     any_idx_d;

  // Result register
  logic               out_valid_q;
  logic [VictimW-1:0] out_victim_q;
  choice_kind_e       out_kind_q;

  logic         advance;
  logic         in_take;
  min_hits_t    hits_ext;
  logic [IdxW:0] pos_inc;
  slot_idx_t    res_idx;
  choice_kind_e res_kind;

  // A non-last beat never needs the result register, so it always moves on.
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || victim_o.ready);
  assign slot_i.ready = !in_valid_q || advance;
  assign in_take = slot_i.valid && slot_i.ready;

  assign hits_ext = MinW'(in_hits_q);
  assign pos_inc  = {1'b0, pos_q} + (IdxW + 1)'(1);

  always_comb begin
    empty_seen_d = empty_seen_q;
    empty_idx_d  = empty_idx_q;
    fit_min_d    = fit_min_q;
    fit_idx_d    = fit_idx_q;
    clean_min_d  = clean_min_q;
    clean_idx_d  = clean_idx_q;
    any_min_d    = any_min_q;
    any_idx_d    = any_idx_q;

    if (!in_occupied_q) begin
      if (!empty_seen_q) begin
        empty_seen_d = 1'b1;
        empty_idx_d  = pos_q;
      end
    end else begin
      if (!in_dirty_q && (in_bsize_q >= in_wanted_q) && (hits_ext < fit_min_q)) begin
        fit_min_d = hits_ext;
        fit_idx_d = pos_q;
      end
      if (!in_dirty_q && (hits_ext < clean_min_q)) begin
        clean_min_d = hits_ext;
        clean_idx_d = pos_q;
      end
      if (hits_ext < any_min_q) begin
        any_min_d = hits_ext;
        any_idx_d = pos_q;
      end
    end

    pos_d = (pos_inc >= (IdxW + 1)'(SlotCount)) ? '0 : pos_inc[IdxW-1:0];

    if (empty_seen_d) begin
      res_idx  = empty_idx_d;
      res_kind = KindEmpty;
    end else if (fit_min_d < HitsCeiling) begin
      res_idx  = fit_idx_d;
      res_kind = KindCleanFit;
    end else if (clean_min_d < HitsCeiling) begin
      res_idx  = clean_idx_d;
      res_kind = KindCleanSmall;
    end else begin
      res_idx  = any_idx_d;
      res_kind = KindAny;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_occupied_q <= slot_i.slot_occupied;
      in_dirty_q    <= slot_i.slot_dirty;
      in_bsize_q    <= slot_i.slot_buffer_size;
      in_hits_q     <= slot_i.slot_hits;
      in_wanted_q   <= slot_i.wanted_size;
      in_last_q     <= slot_i.last_slot;
    end
    if (advance && in_last_q) begin
      out_victim_q <= VictimW'(res_idx);
      out_kind_q   <= res_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pos_q        <= '0;
      empty_seen_q <= 1'b0;
      empty_idx_q  <= '0;
      fit_min_q    <= HitsCeiling;
      fit_idx_q    <= '0;
      clean_min_q  <= HitsCeiling;
      clean_idx_q  <= '0;
      any_min_q    <= HitsCeiling;
      any_idx_q    <= '0;
    end else begin
      if (slot_i.ready) begin
        in_valid_q <= slot_i.valid;
      end

      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (victim_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (advance) begin
        if (in_last_q) begin
          // Request closed: back to idle values for the next one.
          pos_q        <= '0;
          empty_seen_q <= 1'b0;
          empty_idx_q  <= '0;
          fit_min_q    <= HitsCeiling;
          fit_idx_q    <= '0;
          clean_min_q  <= HitsCeiling;
          clean_idx_q  <= '0;
          any_min_q    <= HitsCeiling;
          any_idx_q    <= '0;
        end else begin
          pos_q        <= pos_d;
          empty_seen_q <= empty_seen_d;
          empty_idx_q  <= empty_idx_d;
          fit_min_q    <= fit_min_d;
          fit_idx_q    <= fit_idx_d;
          clean_min_q  <= clean_min_d;
          clean_idx_q  <= clean_idx_d;
          any_min_q    <= any_min_d;
          any_idx_q    <= any_idx_d;
        end
      end
    end
  end

  assign victim_o.valid       = out_valid_q;
  assign victim_o.victim_slot = out_victim_q;
  assign victim_o.choice_kind = out_kind_q;

endmodule

### sim/tb_cache_slot_victim_select_core.sv
`timescale 1ns / 1ps

module tb_cache_slot_victim_select_core
  import csvs_pkg::*;
;

  typedef struct packed {
    logic             occupied;
    logic             dirty;
    logic [SizeW-1:0] buf_size;
    logic [HitsW-1:0] hits;
    logic [SizeW-1:0] wanted;
    logic             last;
  } slot_beat_t;

  typedef struct packed {
    logic [VictimW-1:0] slot;
    choice_kind_e       kind;
  } victim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  csvs_slot_if   slot_bus ();
  csvs_victim_if victim_bus ();

  cache_slot_victim_select_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .slot_i   (slot_bus),
    .victim_o (victim_bus)
  );

  // Driven side of both channels, known from time zero.
  logic       src_valid = 1'b0;
  slot_beat_t slot_drv = '0;
  logic       sink_ready = 1'b0;

  assign slot_bus.valid            = src_valid;
  assign slot_bus.slot_occupied    = slot_drv.occupied;
  assign slot_bus.slot_dirty       = slot_drv.dirty;
  assign slot_bus.slot_buffer_size = slot_drv.buf_size;
  assign slot_bus.slot_hits        = slot_drv.hits;
  assign slot_bus.wanted_size      = slot_drv.wanted;
  assign slot_bus.last_slot        = slot_drv.last;
  assign victim_bus.ready          = sink_ready;

  slot_beat_t slot_beats[$];
  victim_t    pending_victims[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int victims_checked = 0;
  int kinds_seen[4] = '{0, 0, 0, 0};

  // Scan state of the request in flight.
  int        scan_pos;
  bit        empty_found;
  int        empty_slot;
  min_hits_t fit_best;
  int        fit_slot;
  min_hits_t clean_best;
  int        clean_slot;
  min_hits_t any_best;
  int        any_slot;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void restart_scan();
    scan_pos    = 0;
    empty_found = 1'b0;
    empty_slot  = 0;
    fit_best    = HitsCeiling;
    fit_slot    = 0;
    clean_best  = HitsCeiling;
    clean_slot  = 0;
    any_best    = HitsCeiling;
    any_slot    = 0;
  endfunction

  // Folds one slot into the running minima; closes the request on last.
  function automatic void scan_slot(input slot_beat_t b);
    min_hits_t h;
    victim_t   v;
    h = {1'b0, b.hits};
    if (!b.occupied) begin
      if (!empty_found) begin
        empty_found = 1'b1;
        empty_slot  = scan_pos;
      end
    end else begin
      if (!b.dirty && b.buf_size >= b.wanted && h < fit_best) begin
        fit_best = h;
        fit_slot = scan_pos;
      end
      if (!b.dirty && h < clean_best) begin
        clean_best = h;
        clean_slot = scan_pos;
      end
      if (h < any_best) begin
        any_best = h;
        any_slot = scan_pos;
      end
    end
    scan_pos = (scan_pos + 1 >= SlotCount) ? 0 : scan_pos + 1;
    if (b.last) begin
      if (empty_found) begin
        v.slot = VictimW'(empty_slot);
        v.kind = KindEmpty;
      end else if (fit_best < HitsCeiling) begin
        v.slot = VictimW'(fit_slot);
        v.kind = KindCleanFit;
      end else if (clean_best < HitsCeiling) begin
        v.slot = VictimW'(clean_slot);
        v.kind = KindCleanSmall;
      end else begin
        v.slot = VictimW'(any_slot);
        v.kind = KindAny;
      end
      pending_victims.push_back(v);
      restart_scan();
    end
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void push_beat(input logic occ, input logic dirty,
                                    input logic [SizeW-1:0] bsize,
                                    input logic [HitsW-1:0] hits,
                                    input logic [SizeW-1:0] want, input logic last);
    slot_beat_t b;
    b.occupied = occ;
    b.dirty    = dirty;
    b.buf_size = bsize;
    b.hits     = hits;
    b.wanted   = want;
    b.last     = last;
    slot_beats.push_back(b);
  endfunction

  // Mostly full 16-slot scans with per-request biases so that every choice
  // kind shows up; some short, some wrapping, some pure noise.
  function automatic int queue_random_request();
    int               n_slots;
    int               empty_pct;
    int               dirty_pct;
    int               hits_top;
    int               near;
    bit               noisy;
    logic [SizeW-1:0] want;
    slot_beat_t       b;
    case ($urandom_range(0, 9))
      0, 1:    n_slots = $urandom_range(1, 15);
      2:       n_slots = $urandom_range(17, 40);
      default: n_slots = 16;
    endcase
    noisy = ($urandom_range(0, 99) < 15);
    case ($urandom_range(0, 4))
      0:       empty_pct = 50;
      1:       empty_pct = 3;
      default: empty_pct = 0;
    endcase
    case ($urandom_range(0, 3))
      0:       dirty_pct = 0;
      1:       dirty_pct = 40;
      2:       dirty_pct = 90;
      default: dirty_pct = 100;
    endcase
    case ($urandom_range(0, 2))
      0:       hits_top = 3;
      1:       hits_top = 255;
      default: hits_top = 0;
    endcase
    case ($urandom_range(0, 5))
      0:       want = '0;
      1:       want = '1;
      default: want = SizeW'($urandom_range(0, 65535));
    endcase
    for (int i = 0; i < n_slots; i++) begin
      if (noisy) begin
        b.occupied = 1'($urandom_range(0, 1));
        b.dirty    = 1'($urandom_range(0, 1));
        b.buf_size = SizeW'($urandom);
        b.hits     = HitsW'($urandom);
        b.wanted   = SizeW'($urandom);
      end else begin
        b.occupied = ($urandom_range(0, 99) >= empty_pct);
        b.dirty    = ($urandom_range(0, 99) < dirty_pct);
        case ($urandom_range(0, 5))
          0:       b.buf_size = '0;
          1:       b.buf_size = '1;
          2:       b.buf_size = SizeW'($urandom);
          default: begin
            near = int'(want) + int'($urandom_range(0, 2)) - 1;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            b.buf_size = SizeW'(near);
          end
        endcase
        b.hits   = HitsW'($urandom_range(0, hits_top));
        b.wanted = want;
      end
      b.last = (i == n_slots - 1);
      slot_beats.push_back(b);
    end
    return n_slots;
  endfunction

  // Slot driver: predicts on every accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
      restart_scan();
    end else begin
      if (src_valid && slot_bus.ready) begin
        scan_slot(slot_drv);
        beats_sent++;
      end
      if (!src_valid || slot_bus.ready) begin
        if (slot_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          src_valid <= 1'b1;
          slot_drv  <= slot_beats.pop_front();
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Victim monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else begin
      if (victim_bus.valid && sink_ready) begin
        if (pending_victims.size() == 0) begin
          flag_mismatch($sformatf("unexpected victim beat slot=%0d kind=%0d",
                                  victim_bus.victim_slot, victim_bus.choice_kind));
        end else begin
          if (victim_bus.victim_slot !== pending_victims[0].slot)
            flag_mismatch($sformatf("victim_slot %0d, expected %0d",
                                    victim_bus.victim_slot, pending_victims[0].slot));
          if (victim_bus.choice_kind !== pending_victims[0].kind)
            flag_mismatch($sformatf("choice_kind %0d, expected %s",
                                    victim_bus.choice_kind,
                                    pending_victims[0].kind.name()));
          kinds_seen[pending_victims[0].kind]++;
          victims_checked++;
          void'(pending_victims.pop_front());
        end
      end
      sink_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    int queued;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (phase == 0) begin
        // lone empty slot whose dirty mark must be ignored
        push_beat(1'b0, 1'b1, '1, '1, '1, 1'b1);
        // exact fit at the top hit count
        push_beat(1'b1, 1'b0, '1, '1, '1, 1'b1);
        // clean but too small
        push_beat(1'b1, 1'b0, '0, '1, '1, 1'b1);
        // only a dirty slot left
        push_beat(1'b1, 1'b1, '1, '0, '0, 1'b1);
        // empty slot after an occupied one
        push_beat(1'b1, 1'b1, '0, '0, '0, 1'b0);
        push_beat(1'b0, 1'b0, '0, '0, '0, 1'b1);
        // tie on hits goes to the earlier slot
        push_beat(1'b1, 1'b0, 16'd100, 8'd5, 16'd100, 1'b0);
        push_beat(1'b1, 1'b0, 16'd200, 8'd5, 16'd100, 1'b1);
        // one slot past the slot count: index wraps
        for (int i = 0; i < 17; i++)
          push_beat(1'b1, 1'b1, 16'h1234, (i == 16) ? 8'd3 : 8'd7, 16'h1234, i == 16);
      end
      queued = 0;
      while (queued < 225) queued += queue_random_request();
      while (slot_beats.size() != 0 || src_valid || pending_victims.size() != 0)
        @(posedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    $display("summary: %0d slot beats over four idle/stall phases, %0d victims checked",
             beats_sent, victims_checked);
    $display("summary: kinds seen - empty %0d, clean fit %0d, clean small %0d, any %0d",
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
src/csvs_pkg.sv
src/csvs_slot_if.sv
src/csvs_victim_if.sv
src/cache_slot_victim_select_core.sv
sim/tb_cache_slot_victim_select_core.sv
